// ===== design/i2c_target_register_map_defines.svh =====
// ----------------------------------------------------------------------------
// I2C target register map: assertion macros
// Shared macros for the concurrent checks of the register map block.
// ----------------------------------------------------------------------------
`ifndef I2C_TARGET_REGISTER_MAP_DEFINES_SVH
`define I2C_TARGET_REGISTER_MAP_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define TRM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("register map check failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define TRM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("register map check failed");

`endif

// ===== design/i2ctrm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C target register map package
// Types, codes and the identification strings of the register map.
// ----------------------------------------------------------------------------
package i2ctrm_pkg;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_ACK   = 2'd2;

	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_ACK  = 2'd1;
	localparam logic [1:0] REPLY_NACK = 2'd2;

	localparam logic [1:0] PH_ADDR  = 2'd0;
	localparam logic [1:0] PH_REG   = 2'd1;
	localparam logic [1:0] PH_WRITE = 2'd2;
	localparam logic [1:0] PH_READ  = 2'd3;

	localparam logic [7:0] REG_VERSION = 8'h00;
	localparam logic [7:0] REG_VENDOR  = 8'h08;
	localparam logic [7:0] REG_PRODUCT = 8'h10;
	localparam logic [7:0] REG_ENABLES = 8'h42;
	localparam logic [7:0] REG_EN_CLR  = 8'h43;
	localparam logic [7:0] REG_EN_SET  = 8'h44;
	localparam logic [7:0] REG_DUTY    = 8'h50;
	localparam logic [7:0] DUTY_MASK   = 8'hFC;
	localparam logic [7:0] NO_REG      = 8'h80;

	localparam logic [6:0] DEV_ADDR_RESET = 7'd1;
	localparam logic [3:0] OFFSET_MAX     = 4'd15;

	localparam logic [63:0] STR_VERSION = 64'h56312E3020202020;
	localparam logic [63:0] STR_VENDOR  = 64'h545552544C4D4B52;
	localparam logic [63:0] STR_PRODUCT = 64'h495250464C494E4B;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] bus_byte;
		logic       master_nack;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t item;
	} stage_t;

	typedef struct packed {
		logic [1:0] reply;
		logic       send_valid;
		logic [7:0] send_byte;
		logic [3:0] channel_enables;
		logic [7:0] duty_ch0;
		logic [7:0] duty_ch1;
		logic [7:0] duty_ch2;
		logic [7:0] duty_ch3;
	} rsp_t;

	function automatic logic reg_known(input logic [7:0] r);
		return r == REG_VERSION || r == REG_VENDOR || r == REG_PRODUCT ||
			r == REG_ENABLES || r == REG_EN_CLR || r == REG_EN_SET ||
			(r & DUTY_MASK) == REG_DUTY;
	endfunction

	function automatic logic reg_writable(input logic [7:0] r);
		return (r & DUTY_MASK) == REG_DUTY || r == REG_ENABLES ||
			r == REG_EN_CLR || r == REG_EN_SET;
	endfunction

	// Character of an identification string; the first character is the top byte.
	function automatic logic [7:0] msg_char(input logic [7:0] r, input logic [2:0] idx);
		logic [63:0] s;
		logic [5:0]  lsb;
		s   = (r == REG_VERSION) ? STR_VERSION :
			(r == REG_VENDOR) ? STR_VENDOR : STR_PRODUCT;
		lsb = {~idx, 3'b000};
		return s[lsb +: 8];
	endfunction

endpackage

// ===== design/i2ctrm_if.sv =====
// ----------------------------------------------------------------------------
// I2C target register map channel interfaces
// Bus event, result and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
interface i2ctrm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] bus_byte;
	logic       master_nack;
	modport source (output valid, opcode, bus_byte, master_nack, input ready);
	modport sink (input valid, opcode, bus_byte, master_nack, output ready);
endinterface

interface i2ctrm_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] reply;
	logic       send_valid;
	logic [7:0] send_byte;
	logic [3:0] channel_enables;
	logic [7:0] duty_ch0;
	logic [7:0] duty_ch1;
	logic [7:0] duty_ch2;
	logic [7:0] duty_ch3;
	modport source (output valid, reply, send_valid, send_byte, channel_enables,
		duty_ch0, duty_ch1, duty_ch2, duty_ch3, input ready);
	modport sink (input valid, reply, send_valid, send_byte, channel_enables,
		duty_ch0, duty_ch1, duty_ch2, duty_ch3, output ready);
endinterface

interface i2ctrm_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/i2ctrm_in_stage.sv =====
// ----------------------------------------------------------------------------
// I2C target register map input stage
// Registers one bus event so that a new one can enter while a result waits.
// ----------------------------------------------------------------------------
module i2ctrm_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	i2ctrm_req_if.sink         req,
	input  logic               advance,
	output i2ctrm_pkg::stage_t s1
);

	logic              valid_s1;
	i2ctrm_pkg::req_t  item_s1;

	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.opcode      <= req.opcode;
			item_s1.bus_byte    <= req.bus_byte;
			item_s1.master_nack <= req.master_nack;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.item  = item_s1;

endmodule

// ===== design/i2ctrm_engine.sv =====
// ----------------------------------------------------------------------------
// I2C target register map engine
// Holds the bus phase and register state, decodes one event a cycle while
// the result register is free or taken by rsp, and registers the result.
// ----------------------------------------------------------------------------
module i2ctrm_engine (
	input  logic               clk,
	input  logic               arst_n,
	i2ctrm_cfg_if.sink         cfg,
	input  i2ctrm_pkg::stage_t s1,
	output logic               advance,
	i2ctrm_rsp_if.source       rsp
);

	logic [6:0] dev_addr_q;
	logic [1:0] phase_q, phase_d;
	logic [7:0] ptr_q, ptr_d;
	logic [3:0] off_q, off_d;
	logic [3:0] en_q, en_d;
	logic [7:0] duty_q [4];
	logic [7:0] duty_d [4];
	logic       out_valid_q;
	i2ctrm_pkg::rsp_t out_q, res;

	logic [1:0] op;
	logic [7:0] b;
	logic [3:0] send_off;
	logic       do_send;
	logic [7:0] rd_byte;

	assign advance   = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;
	assign op        = s1.item.opcode;
	assign b         = s1.item.bus_byte;

	always_comb begin
		rd_byte = 8'h00;
		if (ptr_q == i2ctrm_pkg::REG_VERSION || ptr_q == i2ctrm_pkg::REG_VENDOR ||
			ptr_q == i2ctrm_pkg::REG_PRODUCT) begin
			if (!send_off[3]) begin
				rd_byte = i2ctrm_pkg::msg_char(ptr_q, send_off[2:0]);
			end
		end else if (send_off == 4'd0) begin
			if (ptr_q == i2ctrm_pkg::REG_ENABLES) begin
				rd_byte = {en_q, 4'h0};
			end else if ((ptr_q & i2ctrm_pkg::DUTY_MASK) == i2ctrm_pkg::REG_DUTY) begin
				rd_byte = duty_q[ptr_q[1:0]];
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		ptr_d     = ptr_q;
		en_d      = en_q;
		duty_d    = duty_q;
		do_send   = 1'b0;
		send_off  = off_q;
		res.reply = i2ctrm_pkg::REPLY_NONE;
		case (op)
			i2ctrm_pkg::OP_START: begin
				phase_d = i2ctrm_pkg::PH_ADDR;
			end
			i2ctrm_pkg::OP_ACK: begin
				if (s1.item.master_nack) begin
					phase_d = i2ctrm_pkg::PH_ADDR;
					ptr_d   = i2ctrm_pkg::NO_REG;
				end else if (phase_q == i2ctrm_pkg::PH_READ) begin
					do_send = 1'b1;
				end
			end
			i2ctrm_pkg::OP_BYTE: begin
				unique case (phase_q)
					i2ctrm_pkg::PH_ADDR: begin
						if (b[7:1] != dev_addr_q) begin
							res.reply = i2ctrm_pkg::REPLY_NACK;
						end else if (b[0]) begin
							if (!ptr_q[7]) begin
								phase_d   = i2ctrm_pkg::PH_READ;
								res.reply = i2ctrm_pkg::REPLY_ACK;
								send_off  = 4'd0;
								do_send   = 1'b1;
							end else begin
								res.reply = i2ctrm_pkg::REPLY_NACK;
							end
						end else if (ptr_q[7]) begin
							phase_d   = i2ctrm_pkg::PH_REG;
							res.reply = i2ctrm_pkg::REPLY_ACK;
						end else if (i2ctrm_pkg::reg_writable(ptr_q)) begin
							phase_d   = i2ctrm_pkg::PH_WRITE;
							res.reply = i2ctrm_pkg::REPLY_ACK;
						end else begin
							res.reply = i2ctrm_pkg::REPLY_NACK;
						end
					end
					i2ctrm_pkg::PH_REG: begin
						phase_d = i2ctrm_pkg::PH_ADDR;
						if (i2ctrm_pkg::reg_known(b)) begin
							ptr_d     = b;
							res.reply = i2ctrm_pkg::REPLY_ACK;
						end else begin
							res.reply = i2ctrm_pkg::REPLY_NACK;
						end
					end
					i2ctrm_pkg::PH_WRITE: begin
						res.reply = i2ctrm_pkg::REPLY_ACK;
						if (ptr_q == i2ctrm_pkg::REG_ENABLES) begin
							en_d = b[7:4];
						end else if (ptr_q == i2ctrm_pkg::REG_EN_CLR) begin
							en_d = en_q & ~b[3:0];
						end else if (ptr_q == i2ctrm_pkg::REG_EN_SET) begin
							en_d = en_q | b[3:0];
						end else if ((ptr_q & i2ctrm_pkg::DUTY_MASK) ==
							i2ctrm_pkg::REG_DUTY) begin
							duty_d[ptr_q[1:0]] = b;
						end else begin
							res.reply = i2ctrm_pkg::REPLY_NACK;
						end
						phase_d = i2ctrm_pkg::PH_ADDR;
						ptr_d   = i2ctrm_pkg::NO_REG;
					end
					default: begin
						res.reply = i2ctrm_pkg::REPLY_NACK;
					end
				endcase
				if (res.reply == i2ctrm_pkg::REPLY_NACK) begin
					phase_d = i2ctrm_pkg::PH_ADDR;
					ptr_d   = i2ctrm_pkg::NO_REG;
				end
			end
			default: begin
			end
		endcase
		off_d = send_off;
		if (do_send && send_off != i2ctrm_pkg::OFFSET_MAX) begin
			off_d = send_off + 4'd1;
		end
		res.send_valid      = do_send;
		res.send_byte       = do_send ? rd_byte : 8'h00;
		res.channel_enables = en_d;
		res.duty_ch0        = duty_d[0];
		res.duty_ch1        = duty_d[1];
		res.duty_ch2        = duty_d[2];
		res.duty_ch3        = duty_d[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= i2ctrm_pkg::DEV_ADDR_RESET;
		end else if (cfg.valid) begin
			dev_addr_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2ctrm_pkg::PH_ADDR;
			ptr_q       <= i2ctrm_pkg::NO_REG;
			off_q       <= 4'd0;
			en_q        <= 4'd0;
			duty_q      <= '{default: 8'h00};
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1.valid;
			if (s1.valid) begin
				phase_q <= phase_d;
				ptr_q   <= ptr_d;
				off_q   <= off_d;
				en_q    <= en_d;
				duty_q  <= duty_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1.valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.reply           = out_q.reply;
	assign rsp.send_valid      = out_q.send_valid;
	assign rsp.send_byte       = out_q.send_byte;
	assign rsp.channel_enables = out_q.channel_enables;
	assign rsp.duty_ch0        = out_q.duty_ch0;
	assign rsp.duty_ch1        = out_q.duty_ch1;
	assign rsp.duty_ch2        = out_q.duty_ch2;
	assign rsp.duty_ch3        = out_q.duty_ch3;

endmodule

// ===== design/i2c_target_register_map.sv =====
// ----------------------------------------------------------------------------
// I2C target register map
// Byte-level I2C target with a register pointer, identification strings,
// channel enables and four PWM duty bytes.
// ----------------------------------------------------------------------------
//  Channel  Dir  Transaction
//  req      in   one bus event: start, byte from master or acknowledge bit
//  rsp      out  one result per event: reply, byte to send, register snapshot
//  cfg      in   write of the seven-bit device address, always ready
//
//  Each event passes from acceptance to result through an input register
//  and a result register with one step of decode logic between them.
//  One transaction per cycle is sustained in both directions while rsp is ready.
//  When rsp stalls, req still takes one more event if the input register is empty.
//  Reset is asynchronous and leaves no clearing pass; the block is ready at once.
// ----------------------------------------------------------------------------
`include "i2c_target_register_map_defines.svh"

module i2c_target_register_map (
	input  logic          clk,
	input  logic          arst_n,
	i2ctrm_req_if.sink    req,
	i2ctrm_rsp_if.source  rsp,
	i2ctrm_cfg_if.sink    cfg
);

	i2ctrm_pkg::stage_t s1;
	logic               advance;

	i2ctrm_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.advance (advance),
		.s1      (s1)
	);

	i2ctrm_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.s1      (s1),
		.advance (advance),
		.rsp     (rsp)
	);

	`TRM_ASSERT_NEXT(a_accept_loads_stage, req.valid && req.ready, s1.valid)
	`TRM_ASSERT_NEXT(a_stage_held_on_stall, s1.valid && !advance, s1.valid && $stable(s1.item))
	`TRM_ASSERT_SAME(a_send_not_refused, rsp.valid && rsp.send_valid, rsp.reply != i2ctrm_pkg::REPLY_NACK)
	`TRM_ASSERT_SAME(a_idle_byte_zero, rsp.valid && !rsp.send_valid, rsp.send_byte == 8'h00)

endmodule
